FILE: rtl/sms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_pkg
// Shared widths, action codes, register indexes and the result beat type of
// the SPI master byte shifter.
// ----------------------------------------------------------------------------
package sms_pkg;

    localparam int ACTION_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int DIV_W       = 3;
    localparam int PRESCALE_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIVIDER  = 2'd0,
        REG_POLARITY = 2'd1,
        REG_PHASE    = 2'd2,
        REG_ENABLE   = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              tx_empty;
        logic              rx_full;
        logic [BYTE_W-1:0] read_byte;
        logic              overrun;
        logic              busy_res;
    } t_result;

endpackage

FILE: rtl/sms_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface sms_in_if import sms_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   write_byte;
    logic                miso;

    modport source (output valid, action, write_byte, miso, input ready);
    modport sink   (input valid, action, write_byte, miso, output ready);
endinterface

interface sms_out_if import sms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              sclk;
    logic              mosi;
    logic              tx_empty;
    logic              rx_full;
    logic [BYTE_W-1:0] read_byte;
    logic              overrun;
    logic              busy_res;

    modport source (output valid, sclk, mosi, tx_empty, rx_full, read_byte, overrun,
                    busy_res, input ready);
    modport sink   (input valid, sclk, mosi, tx_empty, rx_full, read_byte, overrun,
                    busy_res, output ready);
endinterface

interface sms_cfg_if import sms_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/spi_master_byte_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_byte_shifter
// MSB-first SPI master, modes 0 to 3, behind data and status registers.
// The result beat of an item is registered, queued behind any stalled result.
// One item per cycle until the result buffer fills; one state pass per beat.
// A two-entry result buffer keeps input open while one result is stalled.
// Reset (synchronous, active low) clears state and flags, not result data.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter import sms_pkg::*; #(
    parameter int DATA_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sms_in_if.sink       i_in_ch,
    sms_cfg_if.sink      i_cfg_ch,
    sms_out_if.source    o_out_ch
);

    localparam int EDGE_W = $clog2(2 * DATA_BITS);
    localparam logic [EDGE_W-1:0] EDGE_LAST = EDGE_W'(2 * DATA_BITS - 1);

    logic [DIV_W-1:0]      r_div, n_div;
    logic                  r_cpol, n_cpol;
    logic                  r_cpha, n_cpha;
    logic                  r_en, n_en;
    logic [DATA_BITS-1:0]  r_tx_buf, n_tx_buf;
    logic                  r_tx_pend, n_tx_pend;
    logic [DATA_BITS-1:0]  r_shift, n_shift;
    logic [EDGE_W-1:0]     r_edge, n_edge;
    logic [PRESCALE_W-1:0] r_pre, n_pre;
    logic                  r_clk_lvl, n_clk_lvl;
    logic [DATA_BITS-1:0]  r_rx_buf, n_rx_buf;
    logic                  r_rx_valid, n_rx_valid;
    logic                  r_ovr, n_ovr;
    logic                  r_active, n_active;
    logic                  r_sbit, n_sbit;

    logic                  r_out_valid, r_skid_valid;
    t_result               r_out_data, r_skid_data;
    t_result               n_result;

    logic                  in_beat, out_beat, cfg_beat;
    logic [PRESCALE_W:0]   pre_inc, half;
    logic                  half_end, leading, sample_edge, last_edge;
    logic [DATA_BITS-1:0]  shifted;

    assign in_beat  = i_in_ch.valid && i_in_ch.ready;
    assign out_beat = r_out_valid && o_out_ch.ready;
    assign cfg_beat = i_cfg_ch.valid && i_cfg_ch.ready;

    assign i_in_ch.ready  = !r_skid_valid;
    assign i_cfg_ch.ready = 1'b1;

    assign pre_inc     = {1'b0, r_pre} + 1'b1;
    assign half        = (PRESCALE_W+1)'(1) << r_div;
    assign half_end    = pre_inc >= half;
    assign leading     = !r_edge[0];
    assign sample_edge = r_cpha ? !leading : leading;
    assign last_edge   = r_edge == EDGE_LAST;

    always_comb begin
        n_div      = r_div;
        n_cpol     = r_cpol;
        n_cpha     = r_cpha;
        n_en       = r_en;
        n_tx_buf   = r_tx_buf;
        n_tx_pend  = r_tx_pend;
        n_shift    = r_shift;
        n_edge     = r_edge;
        n_pre      = r_pre;
        n_clk_lvl  = r_clk_lvl;
        n_rx_buf   = r_rx_buf;
        n_rx_valid = r_rx_valid;
        n_ovr      = r_ovr;
        n_active   = r_active;
        n_sbit     = r_sbit;
        shifted    = {r_shift[DATA_BITS-2:0], r_sbit};

        if (in_beat) begin
            case (t_action'(i_in_ch.action))
                ACT_TICK: begin
                    if (r_en) begin
                        if (!r_active) begin
                            n_clk_lvl = r_cpol;
                            if (r_tx_pend) begin
                                n_shift   = r_tx_buf;
                                n_tx_pend = 1'b0;
                                n_active  = 1'b1;
                                n_edge    = '0;
                                n_pre     = '0;
                            end
                        end else if (!half_end) begin
                            n_pre = pre_inc[PRESCALE_W-1:0];
                        end else begin
                            n_pre     = '0;
                            n_clk_lvl = !r_clk_lvl;
                            if (sample_edge) begin
                                n_sbit  = i_in_ch.miso;
                                shifted = {r_shift[DATA_BITS-2:0], i_in_ch.miso};
                                if (last_edge) begin
                                    n_shift = shifted;
                                end
                            end else if (!(r_cpha && r_edge == '0)) begin
                                n_shift = shifted;
                            end
                            if (last_edge) begin
                                n_active  = 1'b0;
                                n_edge    = '0;
                                n_clk_lvl = r_cpol;
                                if (r_rx_valid) begin
                                    n_ovr = 1'b1;
                                end else begin
                                    n_rx_buf   = shifted;
                                    n_rx_valid = 1'b1;
                                end
                            end else begin
                                n_edge = r_edge + 1'b1;
                            end
                        end
                    end
                end
                ACT_WRITE: begin
                    n_tx_buf  = DATA_BITS'(i_in_ch.write_byte);
                    n_tx_pend = 1'b1;
                end
                ACT_READ: begin
                    n_rx_valid = 1'b0;
                    n_ovr      = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (cfg_beat) begin
            case (t_reg_index'(i_cfg_ch.reg_index))
                REG_DIVIDER:  n_div = i_cfg_ch.wdata[DIV_W-1:0];
                REG_POLARITY: begin
                    n_cpol = i_cfg_ch.wdata[0];
                    if (!r_active) begin
                        n_clk_lvl = i_cfg_ch.wdata[0];
                    end
                end
                REG_PHASE:    n_cpha = i_cfg_ch.wdata[0];
                REG_ENABLE:   n_en   = i_cfg_ch.wdata[0];
                default: begin
                end
            endcase
        end

        n_result.sclk      = n_active ? n_clk_lvl : r_cpol;
        n_result.mosi      = n_active && n_shift[DATA_BITS-1];
        n_result.tx_empty  = !n_tx_pend;
        n_result.rx_full   = n_rx_valid;
        n_result.read_byte = BYTE_W'(n_rx_buf);
        n_result.overrun   = n_ovr;
        n_result.busy_res  = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div        <= '0;
            r_cpol       <= 1'b0;
            r_cpha       <= 1'b0;
            r_en         <= 1'b0;
            r_tx_buf     <= '0;
            r_tx_pend    <= 1'b0;
            r_shift      <= '0;
            r_edge       <= '0;
            r_pre        <= '0;
            r_clk_lvl    <= 1'b0;
            r_rx_buf     <= '0;
            r_rx_valid   <= 1'b0;
            r_ovr        <= 1'b0;
            r_active     <= 1'b0;
            r_sbit       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_div      <= n_div;
            r_cpol     <= n_cpol;
            r_cpha     <= n_cpha;
            r_en       <= n_en;
            r_tx_buf   <= n_tx_buf;
            r_tx_pend  <= n_tx_pend;
            r_shift    <= n_shift;
            r_edge     <= n_edge;
            r_pre      <= n_pre;
            r_clk_lvl  <= n_clk_lvl;
            r_rx_buf   <= n_rx_buf;
            r_rx_valid <= n_rx_valid;
            r_ovr      <= n_ovr;
            r_active   <= n_active;
            r_sbit     <= n_sbit;

            if (out_beat) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else if (!in_beat) begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_beat) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_beat) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_beat) begin
                r_out_data <= n_result;
            end
        end else if (in_beat) begin
            if (!r_out_valid) begin
                r_out_data <= n_result;
            end else begin
                r_skid_data <= n_result;
            end
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.sclk      = r_out_data.sclk;
    assign o_out_ch.mosi      = r_out_data.mosi;
    assign o_out_ch.tx_empty  = r_out_data.tx_empty;
    assign o_out_ch.rx_full   = r_out_data.rx_full;
    assign o_out_ch.read_byte = r_out_data.read_byte;
    assign o_out_ch.overrun   = r_out_data.overrun;
    assign o_out_ch.busy_res  = r_out_data.busy_res;

endmodule

FILE: rtl/sms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks on the SPI master byte shifter, bound to the top level.
// ----------------------------------------------------------------------------
module sms_checker import sms_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_rx_full,
    input logic              i_out_overrun,
    input logic [BYTE_W-1:0] i_out_read_byte
);

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_byte);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled result beat changed");

    property p_in_gives_out;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_in_valid && i_in_ready |=> i_out_valid;
    endproperty
    a_in_gives_out: assert property (p_in_gives_out) else $error("accepted beat lost");

    property p_stall_only_when_full;
        @(posedge i_clk) disable iff (!i_rst_n)
            !i_in_ready |-> i_out_valid;
    endproperty
    a_stall_only_when_full: assert property (p_stall_only_when_full)
        else $error("input stalled with no result waiting");

    property p_overrun_needs_full;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_out_valid && i_out_overrun |-> i_out_rx_full;
    endproperty
    a_overrun_needs_full: assert property (p_overrun_needs_full)
        else $error("overrun without a full receive buffer");

endmodule

bind spi_master_byte_shifter sms_checker u_sms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_ch.valid),
    .i_in_ready      (i_in_ch.ready),
    .i_out_valid     (o_out_ch.valid),
    .i_out_ready     (o_out_ch.ready),
    .i_out_rx_full   (o_out_ch.rx_full),
    .i_out_overrun   (o_out_ch.overrun),
    .i_out_read_byte (o_out_ch.read_byte)
);
